// ===== rtl/clsbd_pkg.sv =====
// Shared constants, types and banner tables for the console line splitter.
package clsbd_pkg;

  localparam int LINE_MAX_DEF = 64;

  localparam int BANNER_A_LEN = 20;
  localparam int BANNER_B_LEN = 25;
  localparam int PROG_W       = 5;

  localparam logic [7:0] BYTE_LF = 8'd10;
  localparam logic [7:0] BYTE_CR = 8'd13;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_LINE   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_FLUSH
  } clsbd_state_t;

  function automatic logic [7:0] banner_a_byte(input logic [PROG_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      5'd0:    b = 8'd72;
      5'd1:    b = 8'd101;
      5'd2:    b = 8'd108;
      5'd3:    b = 8'd108;
      5'd4:    b = 8'd111;
      5'd5:    b = 8'd32;
      5'd6:    b = 8'd102;
      5'd7:    b = 8'd114;
      5'd8:    b = 8'd111;
      5'd9:    b = 8'd109;
      5'd10:   b = 8'd32;
      5'd11:   b = 8'd85;
      5'd12:   b = 8'd110;
      5'd13:   b = 8'd105;
      5'd14:   b = 8'd107;
      5'd15:   b = 8'd114;
      5'd16:   b = 8'd97;
      5'd17:   b = 8'd102;
      5'd18:   b = 8'd116;
      5'd19:   b = 8'd33;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] banner_b_byte(input logic [PROG_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      5'd0:    b = 8'd85;
      5'd1:    b = 8'd78;
      5'd2:    b = 8'd68;
      5'd3:    b = 8'd69;
      5'd4:    b = 8'd82;
      5'd5:    b = 8'd76;
      5'd6:    b = 8'd79;
      5'd7:    b = 8'd82;
      5'd8:    b = 8'd68;
      5'd9:    b = 8'd95;
      5'd10:   b = 8'd67;
      5'd11:   b = 8'd95;
      5'd12:   b = 8'd70;
      5'd13:   b = 8'd83;
      5'd14:   b = 8'd95;
      5'd15:   b = 8'd70;
      5'd16:   b = 8'd73;
      5'd17:   b = 8'd76;
      5'd18:   b = 8'd69;
      5'd19:   b = 8'd58;
      5'd20:   b = 8'd32;
      5'd21:   b = 8'd80;
      5'd22:   b = 8'd65;
      5'd23:   b = 8'd83;
      5'd24:   b = 8'd83;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [PROG_W-1:0] advance_a(input logic [PROG_W-1:0] prog,
                                                  input logic [7:0] b);
    logic [PROG_W-1:0] r;
    if (prog < PROG_W'(BANNER_A_LEN) && b == banner_a_byte(prog)) begin
      r = prog + PROG_W'(1);
    end else begin
      r = (b == banner_a_byte(PROG_W'(0))) ? PROG_W'(1) : PROG_W'(0);
    end
    return r;
  endfunction

  function automatic logic [PROG_W-1:0] advance_b(input logic [PROG_W-1:0] prog,
                                                  input logic [7:0] b);
    logic [PROG_W-1:0] r;
    if (prog < PROG_W'(BANNER_B_LEN) && b == banner_b_byte(prog)) begin
      r = prog + PROG_W'(1);
    end else begin
      r = (b == banner_b_byte(PROG_W'(0))) ? PROG_W'(1) : PROG_W'(0);
    end
    return r;
  endfunction

endpackage

// ===== rtl/console_line_splitter_banner_detect.sv =====
// Console line splitter with banner detection: line store memory, flush sequencer, output register.
// Each console byte is one input item. An ordinary byte, while fewer than LINE_MAX-1 bytes are
// stored, or a line end on an empty line, is taken and gives one result. A line end on a line
// of n stored bytes, or an ordinary byte arriving when LINE_MAX-1 bytes are stored, starts a
// flush that reads the line memory one byte per cycle, while the output register is free,
// through its single registered read port; no new item is accepted during the flush. An output
// register holds each result; a new item is taken no earlier than the cycle in which the previous
// result leaves. Results carry the sticky started flag, set once either banner string has matched.
module console_line_splitter_banner_detect #(
  parameter int LINE_MAX = clsbd_pkg::LINE_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_line_byte,
  output logic       out_last_of_input,
  output logic       out_started
);

  localparam int DEPTH  = LINE_MAX - 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEN_W  = $clog2(LINE_MAX);
  localparam int PW     = clsbd_pkg::PROG_W;

  logic [7:0] line_mem [0:DEPTH-1];

  clsbd_pkg::clsbd_state_t state_r, state_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [PW-1:0]     prog_a_r, prog_a_nxt;
  logic [PW-1:0]     prog_b_r, prog_b_nxt;
  logic              started_r, started_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic              ostart_r, ostart_nxt;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [7:0]        pend_byte_r, pend_byte_nxt;
  logic [7:0]        rd_data_r;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  logic slot_free;
  logic accept;
  logic is_eol;
  logic full;
  logic is_last;
  logic [PW-1:0] adv_a;
  logic [PW-1:0] adv_b;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == clsbd_pkg::ST_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign is_eol    = (in_byte == clsbd_pkg::BYTE_LF) || (in_byte == clsbd_pkg::BYTE_CR);
  assign full      = (len_r == LEN_W'(LINE_MAX - 1));
  assign is_last   = ((LEN_W'(rd_idx_r) + LEN_W'(1)) == len_r);
  assign adv_a     = clsbd_pkg::advance_a(prog_a_r, in_byte);
  assign adv_b     = clsbd_pkg::advance_b(prog_b_r, in_byte);

  assign out_valid         = out_valid_r;
  assign out_result_kind   = kind_r;
  assign out_line_byte     = byte_r;
  assign out_last_of_input = last_r;
  assign out_started       = ostart_r;

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    prog_a_nxt    = prog_a_r;
    prog_b_nxt    = prog_b_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    ostart_nxt    = ostart_r;
    rd_idx_nxt    = rd_idx_r;
    pend_vld_nxt  = pend_vld_r;
    pend_byte_nxt = pend_byte_r;
    rd_en         = 1'b0;
    rd_addr       = rd_idx_r;
    wr_en         = 1'b0;
    wr_addr       = len_r[ADDR_W-1:0];
    wr_data       = in_byte;
    unique case (state_r)
      clsbd_pkg::ST_IDLE: begin
        if (accept) begin
          if (!is_eol && !started_r) begin
            prog_a_nxt  = adv_a;
            prog_b_nxt  = adv_b;
            started_nxt = (adv_a == PW'(clsbd_pkg::BANNER_A_LEN)) ||
                          (adv_b == PW'(clsbd_pkg::BANNER_B_LEN));
          end
          priority if (is_eol && len_r == '0) begin
            out_valid_nxt = 1'b1;
            kind_nxt      = clsbd_pkg::KIND_EMPTY;
            byte_nxt      = 8'd0;
            last_nxt      = 1'b1;
            ostart_nxt    = started_r;
          end else if (is_eol || full) begin
            rd_en         = 1'b1;
            rd_addr       = '0;
            rd_idx_nxt    = '0;
            pend_vld_nxt  = !is_eol;
            pend_byte_nxt = in_byte;
            state_nxt     = clsbd_pkg::ST_FLUSH;
          end else begin
            wr_en         = 1'b1;
            len_nxt       = len_r + LEN_W'(1);
            out_valid_nxt = 1'b1;
            kind_nxt      = clsbd_pkg::KIND_STATUS;
            byte_nxt      = 8'd0;
            last_nxt      = 1'b1;
            ostart_nxt    = started_nxt;
          end
        end
      end
      clsbd_pkg::ST_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = clsbd_pkg::KIND_LINE;
          byte_nxt      = rd_data_r;
          last_nxt      = is_last;
          ostart_nxt    = started_r;
          if (is_last) begin
            len_nxt   = pend_vld_r ? LEN_W'(1) : LEN_W'(0);
            wr_en     = pend_vld_r;
            wr_addr   = '0;
            wr_data   = pend_byte_r;
            state_nxt = clsbd_pkg::ST_IDLE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = rd_idx_r + ADDR_W'(1);
            rd_idx_nxt = rd_idx_r + ADDR_W'(1);
          end
        end
      end
      default: state_nxt = clsbd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clsbd_pkg::ST_IDLE;
      len_r       <= '0;
      prog_a_r    <= '0;
      prog_b_r    <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      prog_a_r    <= prog_a_nxt;
      prog_b_r    <= prog_b_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    byte_r      <= byte_nxt;
    last_r      <= last_nxt;
    ostart_r    <= ostart_nxt;
    rd_idx_r    <= rd_idx_nxt;
    pend_vld_r  <= pend_vld_nxt;
    pend_byte_r <= pend_byte_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= line_mem[rd_addr];
    end
  end

  a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == clsbd_pkg::ST_FLUSH) |-> (len_r != '0))
    else $error("flush with empty line store");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(LINE_MAX - 1))
    else $error("line length past limit");

  a_started_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("started flag cleared");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == clsbd_pkg::ST_FLUSH) |-> !in_ready)
    else $error("item accepted during flush");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r != clsbd_pkg::KIND_LINE) |-> last_r)
    else $error("status or empty-line result not last of item");

endmodule
